/* rtl/core/spt_pkg.sv */
// ----------------------------------------------------------------------------
// spt_pkg - shared types and constants for the sector proximity test
// Query and result payloads, register indexes, verdict codes.
// ----------------------------------------------------------------------------
package spt_pkg;

    localparam int COORD_BITS           = 24;
    localparam int HEIGHT_TOLERANCE_DEF = 256;
    localparam int CENTER_LIFT_DEF      = 256;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_ENABLE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_MIN   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_MAX   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_AREA_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COS_HALF    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FULL_CIRCLE = 3'd5;

    typedef enum logic [2:0] {
        VERDICT_PASS     = 3'd0,
        VERDICT_DISABLED = 3'd1,
        VERDICT_BOX      = 3'd2,
        VERDICT_ELEV     = 3'd3,
        VERDICT_DIST     = 3'd4,
        VERDICT_CONE     = 3'd5
    } verdict_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] activator_x;
        logic signed [COORD_BITS-1:0] activator_y;
        logic signed [COORD_BITS-1:0] activator_z;
        logic signed [COORD_BITS-1:0] area_x;
        logic signed [COORD_BITS-1:0] area_y;
        logic signed [COORD_BITS-1:0] area_z;
        logic signed [15:0]           facing_x;
        logic signed [15:0]           facing_y;
    } query_t;

    typedef struct packed {
        logic       activated;
        logic [2:0] verdict;
    } result_t;

endpackage

/* rtl/core/sector_proximity_test_core.sv */
// ----------------------------------------------------------------------------
// sector_proximity_test_core - annular sector containment check
// Box, elevation, ring distance and cone tests on an activator position,
// first failing check sets the verdict.
// ----------------------------------------------------------------------------
// Throughput: one query per cycle; six pipeline stages (deltas, early checks,
// products, sums, then the cone squares over two multiply stages) and the
// output register lie between start and done. busy is always low; the receiver cannot stall.
// Reset: registers return to their documented defaults, pipeline empties.
// ----------------------------------------------------------------------------
module sector_proximity_test_core #(
    parameter int HEIGHT_TOLERANCE = spt_pkg::HEIGHT_TOLERANCE_DEF,
    parameter int CENTER_LIFT      = spt_pkg::CENTER_LIFT_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  spt_pkg::query_t                  query,
    input  logic                             cfg_we,
    input  logic [spt_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [spt_pkg::CFG_DATA_W-1:0]   cfg_data,
    output logic                             done,
    output spt_pkg::result_t                 result
);
    import spt_pkg::*;

    localparam int CW = COORD_BITS;
    localparam int ZW = COORD_BITS + 2;
    localparam logic signed [ZW-1:0] HT_S   = ZW'(HEIGHT_TOLERANCE);
    localparam logic signed [ZW-1:0] LIFT_S = ZW'(CENTER_LIFT);

    // configuration
    logic               enable_reg;
    logic [15:0]        range_min_reg;
    logic [15:0]        range_max_reg;
    logic [15:0]        area_height_reg;
    logic signed [15:0] cos_half_reg;
    logic               full_circle_reg;

    // stage 1: deltas
    logic               v1_reg;
    logic signed [CW:0] dx1_reg, dx1_next;
    logic signed [CW:0] dy1_reg, dy1_next;
    logic signed [ZW-1:0] dz1_reg, dz1_next;
    logic signed [15:0] fx1_reg, fy1_reg;

    // stage 2: early checks
    logic               v2_reg;
    logic [CW:0]        ax_abs, ay_abs;
    logic signed [ZW-1:0] hi_lim;
    verdict_t           vd2_reg, vd2_next;
    logic [15:0]        mx2_reg, my2_reg;
    logic signed [16:0] dx2_reg, dy2_reg;
    logic signed [15:0] fx2_reg, fy2_reg;

    // stage 3: products
    logic               v3_reg;
    verdict_t           vd3_reg;
    logic [31:0]        sqx3_reg, sqx3_next;
    logic [31:0]        sqy3_reg, sqy3_next;
    logic signed [32:0] px3_reg, px3_next;
    logic signed [32:0] py3_reg, py3_next;
    logic [31:0]        rmin_sq3_reg, rmin_sq3_next;
    logic [31:0]        rmax_sq3_reg, rmax_sq3_next;

    // stage 4: sums and distance check
    logic               v4_reg;
    verdict_t           vd4_reg, vd4_next;
    logic [32:0]        d2_4_reg, d2_4_next;
    logic signed [33:0] dot4_reg, dot4_next;

    // stage 5: dot squared, first half of cos^2 * d2
    logic               v5_reg;
    verdict_t           vd5_reg;
    logic [33:0]        dot_abs;
    logic [15:0]        cmag;
    logic [63:0]        dot2_5_reg, dot2_5_next;
    logic [48:0]        t5_reg, t5_next;
    logic               neg5_reg, nz5_reg;

    // stage 6: second half of cos^2 * d2
    logic               v6_reg;
    verdict_t           vd6_reg;
    logic [63:0]        dot2_6_reg;
    logic [63:0]        rhs6_reg, rhs6_next;
    logic               neg6_reg, nz6_reg;

    // output
    logic               cone_fail;
    verdict_t           vd_out_next;
    logic               done_reg;
    result_t            result_reg;

    assign busy   = 1'b0;
    assign done   = done_reg;
    assign result = result_reg;

    assign cmag = cos_half_reg[15] ? unsigned'(-cos_half_reg) : unsigned'(cos_half_reg);

    always_comb
    begin
        dx1_next = (CW+1)'(query.activator_x) - (CW+1)'(query.area_x);
        dy1_next = (CW+1)'(query.activator_y) - (CW+1)'(query.area_y);
        dz1_next = ZW'(query.activator_z) + LIFT_S - ZW'(query.area_z);
    end

    always_comb
    begin
        ax_abs = dx1_reg[CW] ? unsigned'(-dx1_reg) : unsigned'(dx1_reg);
        ay_abs = dy1_reg[CW] ? unsigned'(-dy1_reg) : unsigned'(dy1_reg);
        hi_lim = signed'(ZW'(area_height_reg)) + HT_S;
        if (!enable_reg)
            vd2_next = VERDICT_DISABLED;
        else if (ax_abs > (CW+1)'(range_max_reg) || ay_abs > (CW+1)'(range_max_reg))
            vd2_next = VERDICT_BOX;
        else if (dz1_reg < -HT_S || dz1_reg > hi_lim)
            vd2_next = VERDICT_ELEV;
        else
            vd2_next = VERDICT_PASS;
    end

    // past the box check |dx|,|dy| fit in 16 bits
    always_comb
    begin
        sqx3_next     = 32'(mx2_reg) * 32'(mx2_reg);
        sqy3_next     = 32'(my2_reg) * 32'(my2_reg);
        px3_next      = 33'(fx2_reg) * 33'(dx2_reg);
        py3_next      = 33'(fy2_reg) * 33'(dy2_reg);
        rmin_sq3_next = 32'(range_min_reg) * 32'(range_min_reg);
        rmax_sq3_next = 32'(range_max_reg) * 32'(range_max_reg);
    end

    always_comb
    begin
        d2_4_next = 33'(sqx3_reg) + 33'(sqy3_reg);
        dot4_next = 34'(px3_reg) + 34'(py3_reg);
        if (vd3_reg == VERDICT_PASS &&
            (d2_4_next < 33'(rmin_sq3_reg) || d2_4_next > 33'(rmax_sq3_reg)))
            vd4_next = VERDICT_DIST;
        else
            vd4_next = vd3_reg;
    end

    // |dot| < 2^32 since |facing| <= 2^15 and |delta| < 2^16
    always_comb
    begin
        dot_abs     = dot4_reg[33] ? unsigned'(-dot4_reg) : unsigned'(dot4_reg);
        dot2_5_next = 64'(dot_abs[31:0]) * 64'(dot_abs[31:0]);
        t5_next     = 49'(cmag) * 49'(d2_4_reg);
    end

    always_comb
    begin
        rhs6_next = 64'(cmag) * 64'(t5_reg);
    end

    // sign-aware compare of dot against cos*|delta|
    always_comb
    begin
        if (!neg6_reg)
            cone_fail = (cos_half_reg > 16'sd0) && (dot2_6_reg < rhs6_reg);
        else
            cone_fail = (cos_half_reg >= 16'sd0) || (dot2_6_reg > rhs6_reg);
        if (vd6_reg == VERDICT_PASS && !full_circle_reg && nz6_reg && cone_fail)
            vd_out_next = VERDICT_CONE;
        else
            vd_out_next = vd6_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg      <= 1'b1;
            range_min_reg   <= 16'd0;
            range_max_reg   <= 16'd768;
            area_height_reg <= 16'd512;
            cos_half_reg    <= -16'sd16384;
            full_circle_reg <= 1'b1;
            v1_reg          <= 1'b0;
            v2_reg          <= 1'b0;
            v3_reg          <= 1'b0;
            v4_reg          <= 1'b0;
            v5_reg          <= 1'b0;
            v6_reg          <= 1'b0;
            done_reg        <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_ENABLE:      enable_reg      <= cfg_data[0];
                    REG_RANGE_MIN:   range_min_reg   <= cfg_data;
                    REG_RANGE_MAX:   range_max_reg   <= cfg_data;
                    REG_AREA_HEIGHT: area_height_reg <= cfg_data;
                    REG_COS_HALF:    cos_half_reg    <= signed'(cfg_data);
                    REG_FULL_CIRCLE: full_circle_reg <= cfg_data[0];
                    default:         ;
                endcase
            end
            v1_reg   <= start && !busy;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            v4_reg   <= v3_reg;
            v5_reg   <= v4_reg;
            v6_reg   <= v5_reg;
            done_reg <= v6_reg;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        dx1_reg <= dx1_next;
        dy1_reg <= dy1_next;
        dz1_reg <= dz1_next;
        fx1_reg <= query.facing_x;
        fy1_reg <= query.facing_y;

        vd2_reg <= vd2_next;
        mx2_reg <= ax_abs[15:0];
        my2_reg <= ay_abs[15:0];
        dx2_reg <= dx1_reg[16:0];
        dy2_reg <= dy1_reg[16:0];
        fx2_reg <= fx1_reg;
        fy2_reg <= fy1_reg;

        vd3_reg      <= vd2_reg;
        sqx3_reg     <= sqx3_next;
        sqy3_reg     <= sqy3_next;
        px3_reg      <= px3_next;
        py3_reg      <= py3_next;
        rmin_sq3_reg <= rmin_sq3_next;
        rmax_sq3_reg <= rmax_sq3_next;

        vd4_reg  <= vd4_next;
        d2_4_reg <= d2_4_next;
        dot4_reg <= dot4_next;

        vd5_reg    <= vd4_reg;
        dot2_5_reg <= dot2_5_next;
        t5_reg     <= t5_next;
        neg5_reg   <= dot4_reg[33];
        nz5_reg    <= (d2_4_reg != 33'd0);

        vd6_reg    <= vd5_reg;
        dot2_6_reg <= dot2_5_reg;
        rhs6_reg   <= rhs6_next;
        neg6_reg   <= neg5_reg;
        nz6_reg    <= nz5_reg;

        result_reg.activated <= (vd_out_next == VERDICT_PASS);
        result_reg.verdict   <= vd_out_next;
    end

endmodule

/* test/tb_sector_proximity_test_core.sv */
// ----------------------------------------------------------------------------
// tb_sector_proximity_test_core - self-checking bench for the sector test core
// A directed table covers the verdict codes, field extremes and the corner
// cases of the cone check. Random phases follow, each under a new register
// setting. Untyped transfers are predicted in-bench, and all are checked in order.
// ----------------------------------------------------------------------------
module tb_sector_proximity_test_core;

    timeunit 1ns;
    timeprecision 1ps;

    import spt_pkg::*;

    localparam int WATCHDOG_LIMIT = 500;
    localparam int FLUSH_CYCLES   = 16;
    localparam int NUM_PHASES     = 14;

    // indexes outside the register map, writes must be dropped
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    typedef struct packed {
        logic        en;
        logic [15:0] rmin;
        logic [15:0] rmax;
        logic [15:0] height;
        logic [15:0] cosv;
        logic        full;
    } area_cfg_t;

    typedef struct {
        logic                 is_reg;
        logic [CFG_IDX_W-1:0] idx;
        logic [15:0]          data;
        query_t               q;
        logic                 typed;
        verdict_t             v;
    } stim_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    query_t                query = '0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  done;
    result_t               result;

    area_cfg_t  area_cfg;
    result_t    awaited_verdicts[$];
    stim_row_t  stim_table[$];
    int         mismatch_count = 0;
    int         results_seen = 0;
    int         idle_cycles = 0;

    sector_proximity_test_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .query     (query),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .done      (done),
        .result    (result)
    );

    always #6 clk = ~clk;

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    function automatic verdict_t sector_verdict(query_t q, area_cfg_t c);
        longint            dx, dy, dz, dot, cs;
        longint unsigned   ax, ay, d2, dm, cm, dot2, rhs2, rmin_l, rmax_l;
        if (!c.en)
            return VERDICT_DISABLED;
        dx = longint'($signed(q.activator_x)) - longint'($signed(q.area_x));
        dy = longint'($signed(q.activator_y)) - longint'($signed(q.area_y));
        dz = longint'($signed(q.activator_z)) + CENTER_LIFT_DEF
             - longint'($signed(q.area_z));
        ax = (dx < 0) ? longint'(-dx) : dx;
        ay = (dy < 0) ? longint'(-dy) : dy;
        rmin_l = c.rmin;
        rmax_l = c.rmax;
        if (ax > rmax_l || ay > rmax_l)
            return VERDICT_BOX;
        if (dz < -HEIGHT_TOLERANCE_DEF ||
            dz > longint'(c.height) + HEIGHT_TOLERANCE_DEF)
            return VERDICT_ELEV;
        d2 = ax * ax + ay * ay;
        if (d2 < rmin_l * rmin_l || d2 > rmax_l * rmax_l)
            return VERDICT_DIST;
        // zero XY distance always passes the cone
        if (!c.full && d2 != 0) begin
            cs   = longint'($signed(c.cosv));
            dot  = longint'($signed(q.facing_x)) * dx + longint'($signed(q.facing_y)) * dy;
            dm   = (dot < 0) ? longint'(-dot) : dot;
            cm   = (cs < 0) ? longint'(-cs) : cs;
            dot2 = dm * dm;
            rhs2 = cm * cm * d2;
            if (dot >= 0) begin
                if (cs > 0 && dot2 < rhs2)
                    return VERDICT_CONE;
            end
            else begin
                if (cs >= 0 || dot2 > rhs2)
                    return VERDICT_CONE;
            end
        end
        return VERDICT_PASS;
    endfunction

    function automatic area_cfg_t apply_reg(area_cfg_t c, logic [CFG_IDX_W-1:0] idx,
                                            logic [15:0] data);
        area_cfg_t n;
        n = c;
        case (idx)
            REG_ENABLE:      n.en     = data[0];
            REG_RANGE_MIN:   n.rmin   = data;
            REG_RANGE_MAX:   n.rmax   = data;
            REG_AREA_HEIGHT: n.height = data;
            REG_COS_HALF:    n.cosv   = data;
            REG_FULL_CIRCLE: n.full   = data[0];
            default:         ;
        endcase
        return n;
    endfunction

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------
    task automatic report_mismatch(string what);
        mismatch_count++;
        if (mismatch_count <= 50)
            $display("[%0t] mismatch on result %0d: %s", $time, results_seen, what);
    endtask

    always @(posedge clk) begin
        result_t want;
        if (rst_n && done === 1'b1) begin
            if (awaited_verdicts.size() == 0) begin
                report_mismatch("result strobe with nothing outstanding");
            end
            else begin
                want = awaited_verdicts.pop_front();
                if (result.activated !== want.activated)
                    report_mismatch($sformatf("activated %b, want %b",
                                              result.activated, want.activated));
                if (result.verdict !== want.verdict)
                    report_mismatch($sformatf("verdict %0d, want %0d",
                                              result.verdict, want.verdict));
            end
            results_seen++;
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((start && busy === 1'b0) || done === 1'b1) begin
                idle_cycles <= 0;
            end
            else if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("[%0t] watchdog: no transfer for %0d cycles", $time, idle_cycles);
                $display("Simulation FAILED");
                $finish;
            end
            else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic logic [23:0] rand24();
        logic [31:0] r;
        r = $urandom;
        return r[23:0];
    endfunction

    function automatic logic [15:0] rand16();
        logic [31:0] r;
        r = $urandom;
        return r[15:0];
    endfunction

    function automatic stim_row_t reg_row(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
        stim_row_t row;
        row.is_reg = 1'b1;
        row.idx    = idx;
        row.data   = data;
        row.q      = '0;
        row.typed  = 1'b0;
        row.v      = VERDICT_PASS;
        return row;
    endfunction

    function automatic stim_row_t query_row(int ax, int ay, int az, int bx, int by, int bz,
                                            int fx, int fy, logic typed, verdict_t v);
        stim_row_t row;
        row.is_reg        = 1'b0;
        row.idx           = '0;
        row.data          = '0;
        row.q.activator_x = ax[23:0];
        row.q.activator_y = ay[23:0];
        row.q.activator_z = az[23:0];
        row.q.area_x      = bx[23:0];
        row.q.area_y      = by[23:0];
        row.q.area_z      = bz[23:0];
        row.q.facing_x    = fx[15:0];
        row.q.facing_y    = fy[15:0];
        row.typed         = typed;
        row.v             = v;
        return row;
    endfunction

    function automatic query_t junk_query();
        query_t q;
        q.activator_x = rand24();
        q.activator_y = rand24();
        q.activator_z = rand24();
        q.area_x      = rand24();
        q.area_y      = rand24();
        q.area_z      = rand24();
        q.facing_x    = rand16();
        q.facing_y    = rand16();
        return q;
    endfunction

    // Mostly activators placed around the area so the later checks get exercised.
    function automatic query_t make_query(area_cfg_t c);
        query_t q;
        int     roll, span, bx, by, bz, dx, dy, dz, hmax, fx, fy;
        real    ang;
        roll = $urandom_range(0, 99);
        if (roll < 12)
            return junk_query();
        bx   = int'($urandom_range(0, 16600000)) - 8300000;
        by   = int'($urandom_range(0, 16600000)) - 8300000;
        bz   = int'($urandom_range(0, 16600000)) - 8300000;
        span = int'(c.rmax) + int'(c.rmax) / 4 + 4;
        if (roll < 24) begin
            dx = int'(c.rmax) + int'($urandom_range(0, 2)) - 1;
            dy = ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(0, 2 * span)) - span;
            if ($urandom_range(0, 1) == 1)
                dx = -dx;
            if ($urandom_range(0, 1) == 1) begin
                fx = dx;
                dx = dy;
                dy = fx;
            end
        end
        else begin
            dx = int'($urandom_range(0, 2 * span)) - span;
            dy = int'($urandom_range(0, 2 * span)) - span;
        end
        hmax = int'(c.height) + HEIGHT_TOLERANCE_DEF;
        case ($urandom_range(0, 19))
            0:       dz = -HEIGHT_TOLERANCE_DEF;
            1:       dz = -HEIGHT_TOLERANCE_DEF - 1;
            2:       dz = hmax;
            3:       dz = hmax + 1;
            default: dz = int'($urandom_range(0, hmax + 600)) - 556;
        endcase
        if ($urandom_range(0, 4) != 0) begin
            ang = real'($urandom_range(0, 3599)) * 3.14159265358979 / 1800.0;
            fx  = int'(16384.0 * $cos(ang));
            fy  = int'(16384.0 * $sin(ang));
            q.facing_x = fx[15:0];
            q.facing_y = fy[15:0];
        end
        else begin
            q.facing_x = rand16();
            q.facing_y = rand16();
        end
        dx = bx + dx;
        dy = by + dy;
        dz = bz + dz - CENTER_LIFT_DEF;
        q.area_x      = bx[23:0];
        q.area_y      = by[23:0];
        q.area_z      = bz[23:0];
        q.activator_x = dx[23:0];
        q.activator_y = dy[23:0];
        q.activator_z = dz[23:0];
        return q;
    endfunction

    function automatic area_cfg_t make_phase_cfg(int k);
        area_cfg_t c;
        c = '{en: 1'b1, rmin: 16'd0, rmax: 16'd768, height: 16'd512,
              cosv: 16'hC000, full: 1'b0};
        case (k)
            0: begin
                c.rmax   = 16'hFFFF;
                c.height = 16'hFFFF;
                c.cosv   = 16'd16384;
            end
            1: begin
                c.rmax   = 16'd0;
                c.height = 16'd0;
                c.cosv   = 16'd0;
            end
            2: c.rmax = 16'd1024;
            3: begin
                c.en   = 1'b0;
                c.full = 1'b1;
            end
            4: begin
                c.rmin = 16'd2000;
                c.rmax = 16'd1000;
            end
            5: begin
                c.rmax   = 16'hFFFF;
                c.height = 16'hFFFF;
                c.cosv   = 16'h7FFF;
            end
            default: begin
                c.rmax   = ($urandom_range(0, 4) == 0) ? rand16()
                                                      : 16'($urandom_range(16, 4096));
                c.rmin   = ($urandom_range(0, 3) == 0) ? 16'd0
                                                      : 16'($urandom_range(0, c.rmax));
                c.height = ($urandom_range(0, 3) == 0) ? rand16()
                                                      : 16'($urandom_range(0, 2048));
                c.cosv   = ($urandom_range(0, 4) == 0) ? rand16()
                                                      : 16'(int'($urandom_range(0, 32768)) - 16384);
                c.full   = ($urandom_range(0, 3) == 0);
            end
        endcase
        return c;
    endfunction

    // ------------------------------------------------------------------------
    // Driving
    // ------------------------------------------------------------------------
    task automatic send_query(query_t q, logic typed, verdict_t v);
        result_t want;
        start <= 1'b1;
        query <= q;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        if (!typed)
            v = sector_verdict(q, area_cfg);
        want.activated = (v == VERDICT_PASS);
        want.verdict   = v;
        awaited_verdicts.push_back(want);
    endtask

    task automatic pause_sender();
        int roll, gap;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            gap = 0;
        else if (roll < 85)
            gap = $urandom_range(1, 2);
        else if (roll < 97)
            gap = $urandom_range(3, 10);
        else
            gap = $urandom_range(20, 60);
        if (gap != 0) begin
            start <= 1'b0;
            query <= junk_query();
            repeat (gap) @(posedge clk);
        end
    endtask

    // sender holds off until the pipeline has delivered everything
    task automatic wait_results();
        start <= 1'b0;
        while (awaited_verdicts.size() != 0)
            @(posedge clk);
    endtask

    // cfg_we stays high across back-to-back writes, lowered after the last one
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] data, logic last);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        area_cfg = apply_reg(area_cfg, idx, data);
        if (last)
            cfg_we <= 1'b0;
    endtask

    task automatic program_area(area_cfg_t c);
        logic [15:0] r0, r1;
        r0 = rand16();
        r1 = rand16();
        wait_results();
        write_reg(REG_ENABLE,      {r0[15:1], c.en},   1'b0);
        write_reg(REG_RANGE_MIN,   c.rmin,             1'b0);
        write_reg(REG_RANGE_MAX,   c.rmax,             1'b0);
        write_reg(REG_AREA_HEIGHT, c.height,           1'b0);
        write_reg(REG_COS_HALF,    c.cosv,             1'b0);
        write_reg(REG_FULL_CIRCLE, {r1[15:1], c.full}, 1'b1);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        area_cfg_t phase_cfg;
        logic      no_idle;
        int        n_items;

        area_cfg = '{en: 1'b1, rmin: 16'd0, rmax: 16'd768, height: 16'd512,
                     cosv: 16'hC000, full: 1'b1};

        // reset defaults
        stim_table.push_back(query_row(0, 0, 0, 0, 0, 0, 16384, 0, 1'b1, VERDICT_PASS));
        stim_table.push_back(query_row(8388607, 0, 0, -8388608, 0, 0, 0, 0,
                                       1'b1, VERDICT_BOX));
        stim_table.push_back(query_row(0, -8388608, 0, 0, 8388607, 0, -32768, 32767,
                                       1'b1, VERDICT_BOX));
        stim_table.push_back(query_row(0, 0, -8388608, 0, 0, 8388607, 0, 0,
                                       1'b1, VERDICT_ELEV));
        stim_table.push_back(query_row(0, 0, 8388607, 0, 0, -8388608, 0, 0,
                                       1'b1, VERDICT_ELEV));
        stim_table.push_back(query_row(100, 0, -512, 0, 0, 0, 0, 16384, 1'b0, VERDICT_PASS));
        stim_table.push_back(query_row(0, 0, -513, 0, 0, 0, 0, 0, 1'b1, VERDICT_ELEV));
        stim_table.push_back(query_row(0, 0, 512, 0, 0, 0, 0, 0, 1'b0, VERDICT_PASS));
        stim_table.push_back(query_row(0, 0, 513, 0, 0, 0, 0, 0, 1'b1, VERDICT_ELEV));
        stim_table.push_back(query_row(768, -768, 0, 0, 0, 0, 0, 0, 1'b1, VERDICT_DIST));
        stim_table.push_back(query_row(-768, 0, 0, 0, 0, 0, 0, 0, 1'b0, VERDICT_PASS));
        // disabled area
        stim_table.push_back(reg_row(REG_ENABLE, 16'h0000));
        stim_table.push_back(query_row(0, 0, 0, 0, 0, 0, 0, 0, 1'b1, VERDICT_DISABLED));
        // narrowest cone
        stim_table.push_back(reg_row(REG_ENABLE, 16'h0001));
        stim_table.push_back(reg_row(REG_FULL_CIRCLE, 16'h0000));
        stim_table.push_back(reg_row(REG_COS_HALF, 16'd16384));
        stim_table.push_back(query_row(256, 0, 0, 0, 0, 0, 16384, 0, 1'b0, VERDICT_PASS));
        stim_table.push_back(query_row(256, 0, 0, 0, 0, 0, -16384, 0, 1'b1, VERDICT_CONE));
        stim_table.push_back(query_row(0, 0, 0, 0, 0, 0, -16384, 0, 1'b0, VERDICT_PASS));
        stim_table.push_back(query_row(0, 256, 0, 0, 0, 0, 0, 0, 1'b1, VERDICT_CONE));
        // zero facing with a half-plane cone
        stim_table.push_back(reg_row(REG_COS_HALF, 16'd0));
        stim_table.push_back(query_row(0, 256, 0, 0, 0, 0, 0, 0, 1'b0, VERDICT_PASS));
        // cosine below -1
        stim_table.push_back(reg_row(REG_COS_HALF, 16'h8000));
        stim_table.push_back(query_row(256, 0, 0, 0, 0, 0, -16384, 0, 1'b0, VERDICT_PASS));
        stim_table.push_back(query_row(-8388300, 8388200, 100, -8388000, 8388000, 0,
                                       -32768, 32767, 1'b0, VERDICT_PASS));
        // writes to unmapped indexes, then inner radius above outer
        stim_table.push_back(reg_row(REG_SPARE_LO, 16'hFFFF));
        stim_table.push_back(reg_row(REG_SPARE_HI, 16'h1234));
        stim_table.push_back(reg_row(REG_RANGE_MIN, 16'hFFFF));
        stim_table.push_back(query_row(0, 0, 0, 0, 0, 0, 0, 0, 1'b1, VERDICT_DIST));
        // widest ring and height
        stim_table.push_back(reg_row(REG_RANGE_MIN, 16'h0000));
        stim_table.push_back(reg_row(REG_RANGE_MAX, 16'hFFFF));
        stim_table.push_back(reg_row(REG_AREA_HEIGHT, 16'hFFFF));
        stim_table.push_back(reg_row(REG_FULL_CIRCLE, 16'h0001));
        stim_table.push_back(query_row(65535, -65535, 0, 0, 0, 0, 0, 0, 1'b1, VERDICT_DIST));
        stim_table.push_back(query_row(65535, 0, 65535, 0, 0, 0, 0, 0, 1'b0, VERDICT_PASS));
        stim_table.push_back(query_row(-65536, 0, 0, 0, 0, 0, 0, 0, 1'b1, VERDICT_BOX));
        stim_table.push_back(query_row(8388607, 8388607, 8388607, 8388607, 8388607, 8388607,
                                       16384, 16384, 1'b0, VERDICT_PASS));

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < stim_table.size(); i++) begin
            if (stim_table[i].is_reg) begin
                if (i == 0 || !stim_table[i-1].is_reg)
                    wait_results();
                write_reg(stim_table[i].idx, stim_table[i].data,
                          (i + 1 == stim_table.size()) || !stim_table[i+1].is_reg);
            end
            else begin
                send_query(stim_table[i].q, stim_table[i].typed, stim_table[i].v);
                pause_sender();
            end
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            phase_cfg = make_phase_cfg(p);
            program_area(phase_cfg);
            no_idle = ($urandom_range(0, 3) == 0);
            n_items = phase_cfg.en ? 150 : 40;
            for (int i = 0; i < n_items; i++) begin
                send_query(make_query(area_cfg), 1'b0, VERDICT_PASS);
                if ($urandom_range(0, 149) == 0)
                    wait_results();
                else if (!no_idle)
                    pause_sender();
            end
        end

        wait_results();
        repeat (FLUSH_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
